@@ hw/rtl/set_assoc_cache_tag_policy_core_assert.svh @@
// Assertion macros for the cache tag and policy controller.
// Used by the checker module only.
`ifndef SET_ASSOC_CACHE_TAG_POLICY_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_POLICY_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define SACTP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

@@ hw/rtl/sactp_pkg.sv @@
// Shared types and constants of the cache tag and policy controller.
// No dependencies.
package sactp_pkg;
    localparam int WAYS_DEF = 4;
    localparam int SETS_DEF = 4;
    localparam int TAG_W = 24;
    localparam int CNT_W = 16;
    localparam int STAMP_W = 32;
    localparam int ADDR_W = 32;
    localparam int SET_W = 2;
    localparam int OFS_W = 6;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hffff;
    localparam logic [1:0] LEVEL_MAX = 2'b11;

    localparam logic [2:0] POL_FIFO = 3'd0;
    localparam logic [2:0] POL_RANDOM = 3'd1;
    localparam logic [2:0] POL_LRU = 3'd2;
    localparam logic [2:0] POL_LFU = 3'd3;
    localparam logic [2:0] POL_SC = 3'd4;
    localparam logic [2:0] POL_ESC = 3'd5;

    localparam logic [0:0] REG_POLICY = 1'b0;
    localparam logic [0:0] REG_WRITE_BACK = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the input item, start lookup
        logic scan;     // compare one way (lookup, victim scan or walk)
        logic commit;   // update the chosen line, build the result
    } sactp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_way;   // scan index is at the final way
        logic hit;        // tag matched
        logic empty;      // an invalid way exists
        logic walk_stop;  // pointer entry has no remaining chance
    } sactp_sts_t;
endpackage

@@ hw/rtl/sactp_ctrl.sv @@
// Controller state machine of the cache tag and policy controller.
// Depends on sactp_pkg.
module sactp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  logic [2:0]           policy,
    output sactp_pkg::sactp_cmd_t cmd,
    output logic                 walk_phase,
    output logic                 victim_phase,
    input  sactp_pkg::sactp_sts_t sts
);
    typedef enum logic [2:0] {ST_IDLE, ST_LOOK, ST_VICT, ST_WALK, ST_DONE} state_t;
    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic is_walk;

    assign is_walk = (policy == sactp_pkg::POL_SC) || (policy == sactp_pkg::POL_ESC);
    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign walk_phase = (state_reg == ST_WALK);
    assign victim_phase = (state_reg == ST_VICT);

    // Sequence lookup, victim choice and commit
    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                    state_next = ST_DONE;
                else if (sts.last_way)
                begin
                    if (sts.empty)
                        state_next = ST_DONE;
                    else if (is_walk)
                        state_next = ST_WALK;
                    else
                        state_next = ST_VICT;
                end
            end
            ST_VICT:
            begin
                cmd.scan = 1'b1;
                if (sts.last_way)
                    state_next = ST_DONE;
            end
            ST_WALK:
            begin
                cmd.scan = 1'b1;
                if (sts.walk_stop)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.commit = 1'b1;
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

@@ hw/rtl/sactp_dp.sv @@
// Datapath of the cache tag and policy controller: line state, scans, result.
// Depends on sactp_pkg.
module sactp_dp #(
    parameter int WAYS = sactp_pkg::WAYS_DEF,
    parameter int SETS = sactp_pkg::SETS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sactp_pkg::sactp_cmd_t         cmd,
    input  logic                          walk_phase,
    input  logic                          victim_phase,
    output sactp_pkg::sactp_sts_t         sts,
    input  logic [2:0]                    policy,
    input  logic                          write_back,
    input  logic [66:0]                   in_data,
    output logic [39:0]                   out_data
);
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINES = SETS * WAYS;
    localparam int LW = $clog2(LINES);

    logic [LINES-1:0] valid_reg, dirty_reg, chance_reg;
    logic [1:0] level_reg [LINES];
    logic [WW-1:0] ptr_reg [SETS];
    logic [sactp_pkg::TAG_W-1:0] tag_reg [LINES];
    logic [sactp_pkg::CNT_W-1:0] cnt_reg [LINES];
    logic [sactp_pkg::STAMP_W-1:0] use_reg [LINES];

    logic wr_reg;
    logic [sactp_pkg::TAG_W-1:0] atag_reg;
    logic [sactp_pkg::SET_W-1:0] set_reg;
    logic [sactp_pkg::STAMP_W-1:0] stamp_reg;
    logic [1:0] rnd_reg;
    logic [WW-1:0] idx_reg, way_reg, best_reg;
    logic hit_reg, empty_reg;
    logic [sactp_pkg::STAMP_W-1:0] best_val_reg;
    logic [39:0] out_reg;

    logic [LW-1:0] line_idx, ptr_line, way_line, best_line;
    logic [sactp_pkg::STAMP_W-1:0] cur_val;
    logic [WW-1:0] ptr_cur, ptr_inc, rnd_way;
    logic [4:0] rnd_ext;
    logic stop_now, is_lru;

    logic [WW-1:0] fin_way;
    logic [LW-1:0] fin_line;
    logic fin_fifo, wb_now;

    assign line_idx = LW'(set_reg) * LW'(WAYS) + LW'(idx_reg);
    assign ptr_cur = ptr_reg[set_reg];
    assign ptr_inc = (ptr_cur == WW'(WAYS - 1)) ? '0 : ptr_cur + 1'b1;
    assign ptr_line = LW'(set_reg) * LW'(WAYS) + LW'(ptr_cur);
    assign way_line = LW'(set_reg) * LW'(WAYS) + LW'(way_reg);
    assign best_line = LW'(set_reg) * LW'(WAYS) + LW'(best_reg);
    // Random way modulo WAYS: one compare and subtract covers a 2-bit choice
    assign rnd_ext = {3'd0, rnd_reg};
    assign rnd_way = WW'((rnd_ext < 5'(WAYS)) ? rnd_ext : rnd_ext - 5'(WAYS));
    assign is_lru = (policy == sactp_pkg::POL_LRU);
    assign cur_val = is_lru ? use_reg[line_idx]
                            : {{(sactp_pkg::STAMP_W-sactp_pkg::CNT_W){1'b0}}, cnt_reg[line_idx]};
    assign stop_now = (policy == sactp_pkg::POL_SC) ? !chance_reg[ptr_line]
                                                     : (level_reg[ptr_line] == 2'd0);

    assign sts.last_way = (idx_reg == WW'(WAYS - 1));
    assign sts.hit = !walk_phase && !victim_phase && valid_reg[line_idx]
                     && (tag_reg[line_idx] == atag_reg);
    assign sts.empty = empty_reg || !valid_reg[line_idx];
    assign sts.walk_stop = stop_now;
    assign out_data = out_reg;

    // Capture, scan and select the way
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wr_reg <= in_data[0];
            set_reg <= in_data[8:7];
            atag_reg <= in_data[32:9];
            stamp_reg <= in_data[64:33];
            rnd_reg <= in_data[66:65];
            idx_reg <= '0;
            hit_reg <= 1'b0;
            empty_reg <= 1'b0;
            way_reg <= '0;
        end
        else if (cmd.scan && walk_phase)
        begin
            way_reg <= ptr_cur;
        end
        else if (cmd.scan && victim_phase)
        begin
            idx_reg <= sts.last_way ? idx_reg : idx_reg + 1'b1;
            if (idx_reg == '0 || cur_val < best_val_reg)
            begin
                best_reg <= idx_reg;
                best_val_reg <= cur_val;
            end
        end
        else if (cmd.scan)
        begin
            if (sts.hit)
            begin
                hit_reg <= 1'b1;
                way_reg <= idx_reg;
            end
            else
            begin
                if (!valid_reg[line_idx] && !empty_reg)
                begin
                    empty_reg <= 1'b1;
                    way_reg <= idx_reg;
                end
                idx_reg <= sts.last_way ? '0 : idx_reg + 1'b1;
            end
        end
    end

    // Update line state and advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            chance_reg <= '0;
            for (int i = 0; i < LINES; i++)
                level_reg[i] <= 2'd0;
            for (int s = 0; s < SETS; s++)
                ptr_reg[s] <= '0;
        end
        else if (cmd.scan && walk_phase)
        begin
            ptr_reg[set_reg] <= ptr_inc;
            if (policy == sactp_pkg::POL_SC)
                chance_reg[ptr_line] <= stop_now;
            else if (stop_now)
                level_reg[ptr_line] <= sactp_pkg::LEVEL_MAX;
            else
                level_reg[ptr_line] <= level_reg[ptr_line] - 2'd1;
        end
        else if (cmd.commit && !hit_reg)
        begin
            valid_reg[fin_line] <= 1'b1;
            if (write_back)
                dirty_reg[fin_line] <= wr_reg;
            if (!empty_reg && fin_fifo)
                ptr_reg[set_reg] <= ptr_inc;
        end
        else if (cmd.commit && wr_reg && write_back)
            dirty_reg[way_line] <= 1'b1;
    end

    // Final way: the hit or empty way, else the policy's victim for a miss with full set
    always_comb
    begin
        fin_fifo = 1'b0;
        fin_way = way_reg;
        if (!hit_reg && !empty_reg)
        begin
            case (policy)
                sactp_pkg::POL_RANDOM: fin_way = rnd_way;
                sactp_pkg::POL_LRU, sactp_pkg::POL_LFU: fin_way = best_reg;
                sactp_pkg::POL_SC, sactp_pkg::POL_ESC: fin_way = way_reg;
                default:
                begin
                    fin_way = ptr_cur;
                    fin_fifo = 1'b1;
                end
            endcase
        end
        fin_line = LW'(set_reg) * LW'(WAYS) + LW'(fin_way);
        wb_now = !hit_reg && !empty_reg && write_back && dirty_reg[fin_line];
    end

    // Write tag, counters and result
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (hit_reg)
            begin
                if (cnt_reg[way_line] != sactp_pkg::CNT_MAX)
                    cnt_reg[way_line] <= cnt_reg[way_line] + 1'b1;
                use_reg[way_line] <= stamp_reg;
            end
            else
            begin
                tag_reg[fin_line] <= atag_reg;
                cnt_reg[fin_line] <= '0;
                use_reg[fin_line] <= stamp_reg;
            end
            out_reg[0] <= hit_reg;
            out_reg[2:1] <= 2'(fin_way);
            out_reg[3] <= !hit_reg;
            out_reg[4] <= wb_now;
            out_reg[36:5] <= wb_now ? {tag_reg[fin_line], set_reg, 6'd0} : 32'd0;
            out_reg[37] <= wr_reg && !write_back;
            out_reg[39:38] <= 2'd0;
        end
    end
endmodule

@@ hw/rtl/set_assoc_cache_tag_policy_core.sv @@
// Top level of the cache tag and replacement policy controller.
// Depends on sactp_pkg, sactp_ctrl and sactp_dp.
//
// Usage:
//   s_axis carries one access per transaction: action, address, time_stamp,
//   random_way. m_axis returns one result per access: hit, way, fill_line,
//   write_back_line, victim_address, write_through.
//   cfg writes policy (index 0) or write_back (index 1); write only when idle.
// Timing:
//   One access at a time. Lookup compares one way per cycle and stops at a
//   hit. A full-set miss adds a victim scan over all ways for fifo, random,
//   lru and lfu, or a pointer walk for second chance and enhanced second
//   chance. Then the commit state updates the line, and the result sits in
//   the output register.
// Reset: all lines invalid, dirty and chance bits and pointers cleared,
//   policy fifo, write-back mode.
// Stall: the result holds in its register until taken; the next access is
//   accepted in the cycle after that at the earliest.
module set_assoc_cache_tag_policy_core #(
    parameter int WAYS = sactp_pkg::WAYS_DEF,
    parameter int SETS = sactp_pkg::SETS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[0], address[32:1], time_stamp[64:33], random_way[66:65], zero fill
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // hit[0], way[2:1], fill_line[3], write_back_line[4], victim_address[36:5],
    // write_through[37], zero fill
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data
);
    logic [2:0] policy_reg;
    logic write_back_reg;
    sactp_pkg::sactp_cmd_t cmd;
    sactp_pkg::sactp_sts_t sts;
    logic walk_phase, victim_phase;

    assign cfg_ready = 1'b1;

    // Accept configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= sactp_pkg::POL_FIFO;
            write_back_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sactp_pkg::REG_POLICY: policy_reg <= cfg_data;
                sactp_pkg::REG_WRITE_BACK: write_back_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sactp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .policy(policy_reg), .cmd(cmd),
        .walk_phase(walk_phase), .victim_phase(victim_phase), .sts(sts)
    );

    sactp_dp #(.WAYS(WAYS), .SETS(SETS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .walk_phase(walk_phase), .victim_phase(victim_phase), .sts(sts),
        .policy(policy_reg), .write_back(write_back_reg),
        .in_data(s_axis_tdata[66:0]),
        .out_data(m_axis_tdata)
    );
endmodule

@@ hw/rtl/sactp_checker.sv @@
// Port-level checker of the cache tag and policy controller, bound to the top.
// Depends on set_assoc_cache_tag_policy_core_assert.svh.
`include "set_assoc_cache_tag_policy_core_assert.svh"
module sactp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    // Fill is reported exactly on a miss
    `SACTP_ASSERT(a_fill, clk, rst_n,
        m_axis_tvalid |-> (m_axis_tdata[3] == !m_axis_tdata[0]), "fill mismatch")
    // No write-back on a hit
    `SACTP_ASSERT(a_wb_hit, clk, rst_n,
        (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tdata[4], "write-back on hit")
    // No new access while a result waits
    `SACTP_ASSERT(a_one, clk, rst_n, m_axis_tvalid |-> !s_axis_tready, "accept while result pending")
    // Result holds while stalled
    `SACTP_ASSERT(a_hold, clk, rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
        "stalled result changed")
endmodule

bind set_assoc_cache_tag_policy_core sactp_checker u_sactp_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
